### rtl/sha256md_pkg.sv
// Shared types, round constants and bit functions for the SHA-256 digest block.
// Used by sha256md_sched, sha256md_core and sha256_message_digest; no dependencies.
`default_nettype none

package sha256md_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 61;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned ROUNDS = 64;
	localparam logic [POS_W-1:0] LEN_POS = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic              last_word;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PAD2,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             byte_we;
		logic             pad_we;
		logic             zero_all;
		logic             len_we;
		logic             step;
		logic             rotate;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
		logic [63:0]      bit_len;
	} sched_ctl_t;

	typedef struct packed {
		logic load;
		logic round;
		logic fold;
		logic reinit;
	} core_ctl_t;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] init_hash(input logic [2:0] idx);
		case (idx)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			3'd7: init_hash = 32'h5be0cd19;
			default: init_hash = 32'h6a09e667;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h428a2f98;
		endcase
	endfunction

endpackage

`default_nettype wire

### rtl/sha256md_sched.sv
// Message block buffer and schedule generator: 16-word shift window plus a
// registered schedule word for the next round. Depends on sha256md_pkg.
`default_nettype none

module sha256md_sched (
	input  wire                                  clk,
	input  sha256md_pkg::sched_ctl_t             ctl,
	output logic [sha256md_pkg::WORD_W-1:0]      word
);

	logic [sha256md_pkg::WORD_W-1:0] win_q [16];
	logic [sha256md_pkg::WORD_W-1:0] win_d [16];
	logic [sha256md_pkg::WORD_W-1:0] w_q;
	logic [sha256md_pkg::WORD_W-1:0] new_w;
	logic [3:0]                      widx;
	logic [4:0]                      sh;
	logic [sha256md_pkg::WORD_W-1:0] keep;

	assign widx  = ctl.pos[5:2];
	assign sh    = {ctl.pos[1:0], 3'b000};
	assign keep  = ~(32'hFFFFFFFF >> sh);
	assign new_w = win_q[0] + sha256md_pkg::ssig0(win_q[1]) + win_q[9]
		+ sha256md_pkg::ssig1(win_q[14]);

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			win_d[j] = win_q[j];
		end
		if (ctl.step) begin
			for (int j = 0; j < 15; j++) begin
				win_d[j] = win_q[j+1];
			end
			// first 16 steps rotate the loaded block, later ones append new words
			win_d[15] = ctl.rotate ? win_q[0] : new_w;
		end
		if (ctl.byte_we) begin
			for (int j = 0; j < 16; j++) begin
				if (4'(j) == widx) begin
					win_d[j] = (win_q[j] & ~(32'hFF000000 >> sh)) | ({ctl.data, 24'h0} >> sh);
				end
			end
		end
		if (ctl.pad_we) begin
			for (int j = 0; j < 16; j++) begin
				if (4'(j) == widx) begin
					win_d[j] = (win_q[j] & keep) | ({sha256md_pkg::PAD_BYTE, 24'h0} >> sh);
				end else if (4'(j) > widx) begin
					win_d[j] = '0;
				end
			end
		end
		if (ctl.zero_all) begin
			for (int j = 0; j < 16; j++) begin
				win_d[j] = '0;
			end
		end
		if (ctl.len_we) begin
			win_d[14] = ctl.bit_len[63:32];
			win_d[15] = ctl.bit_len[31:0];
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
		if (ctl.step) begin
			w_q <= ctl.rotate ? win_q[0] : new_w;
		end
	end

	assign word = w_q;

endmodule

`default_nettype wire

### rtl/sha256md_core.sv
// Round unit: working variables a..h, one SHA-256 round per cycle, and the
// chaining value with its fold-in adders. Depends on sha256md_pkg.
`default_nettype none

module sha256md_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  sha256md_pkg::core_ctl_t              ctl,
	input  wire  [sha256md_pkg::WORD_W-1:0]      w,
	input  wire  [sha256md_pkg::WORD_W-1:0]      k,
	input  wire  [2:0]                           rd_idx,
	output logic [sha256md_pkg::WORD_W-1:0]      rd_word
);

	logic [sha256md_pkg::WORD_W-1:0] chain_q [8];
	logic [sha256md_pkg::WORD_W-1:0] var_q [8];
	logic [sha256md_pkg::WORD_W-1:0] t1;
	logic [sha256md_pkg::WORD_W-1:0] t2;
	logic [sha256md_pkg::WORD_W-1:0] ch;
	logic [sha256md_pkg::WORD_W-1:0] maj;

	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1  = var_q[7] + sha256md_pkg::bsig1(var_q[4]) + ch + w + k;
	assign t2  = sha256md_pkg::bsig0(var_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256md_pkg::init_hash(3'(i));
			end
		end else if (ctl.reinit) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256md_pkg::init_hash(3'(i));
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			var_q <= chain_q;
		end else if (ctl.round) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	assign rd_word = chain_q[rd_idx];

endmodule

`default_nettype wire

### rtl/sha256_message_digest.sv
// SHA-256 digest over a byte stream: sequencer, length counter and output port.
// Depends on sha256md_pkg, sha256md_sched and sha256md_core.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | input     | in_valid / in_ready | in_t: data_byte, has_byte, end_of_message
//   out     | output    | out_valid/out_ready | out_t: digest_word, last_word
//
// A byte that does not fill a block is taken in idle. A byte that fills a block
// starts a compression: one load, 64 rounds through the shared round unit, one fold.
// Closing a message adds a pad step and then a compression of each padded block
// (one or two blocks, the second with its own pad step), then 8 digest words,
// one per accepted output handshake. in_ready is high only while idle.
// Reset is asynchronous; it clears the sequencer and counters and loads the initial hash into the chaining value.
`default_nettype none

module sha256_message_digest (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  sha256md_pkg::in_t          in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output sha256md_pkg::out_t         out_data
);

	sha256md_pkg::state_t state_q, state_d;
	sha256md_pkg::state_t after_q, after_d;
	logic [sha256md_pkg::POS_W-1:0] bib_q;
	logic [sha256md_pkg::LEN_W-1:0] len_q;
	logic [5:0]                     rnd_q;
	logic [2:0]                     oidx_q;
	logic                           in_fire;
	logic                           out_fire;
	sha256md_pkg::sched_ctl_t       sctl;
	sha256md_pkg::core_ctl_t        cctl;
	logic [sha256md_pkg::WORD_W-1:0] sched_word;
	logic [sha256md_pkg::WORD_W-1:0] chain_word;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		after_d = after_q;
		case (state_q)
			sha256md_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_data.has_byte && (bib_q == 6'd63)) begin
						state_d = sha256md_pkg::ST_LOAD;
						after_d = in_data.end_of_message ? sha256md_pkg::ST_PAD
							: sha256md_pkg::ST_IDLE;
					end else if (in_data.end_of_message) begin
						state_d = sha256md_pkg::ST_PAD;
					end
				end
			end
			sha256md_pkg::ST_PAD: begin
				state_d = sha256md_pkg::ST_LOAD;
				after_d = (bib_q < sha256md_pkg::LEN_POS) ? sha256md_pkg::ST_OUT
					: sha256md_pkg::ST_PAD2;
			end
			sha256md_pkg::ST_PAD2: begin
				state_d = sha256md_pkg::ST_LOAD;
				after_d = sha256md_pkg::ST_OUT;
			end
			sha256md_pkg::ST_LOAD: begin
				state_d = sha256md_pkg::ST_ROUND;
			end
			sha256md_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = sha256md_pkg::ST_FOLD;
				end
			end
			sha256md_pkg::ST_FOLD: begin
				state_d = after_q;
			end
			sha256md_pkg::ST_OUT: begin
				if (out_fire && (oidx_q == 3'd7)) begin
					state_d = sha256md_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256md_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and unit controls
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		sctl          = '0;
		sctl.pos      = bib_q;
		sctl.data     = in_data.data_byte;
		sctl.bit_len  = {len_q, 3'b000};
		sctl.rotate   = (state_q == sha256md_pkg::ST_LOAD) || (rnd_q < 6'd15);
		cctl          = '0;
		case (state_q)
			sha256md_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				sctl.byte_we = in_fire && in_data.has_byte;
			end
			sha256md_pkg::ST_PAD: begin
				sctl.pad_we = 1'b1;
				sctl.len_we = bib_q < sha256md_pkg::LEN_POS;
			end
			sha256md_pkg::ST_PAD2: begin
				sctl.zero_all = 1'b1;
				sctl.len_we   = 1'b1;
			end
			sha256md_pkg::ST_LOAD: begin
				cctl.load = 1'b1;
				sctl.step = 1'b1;
			end
			sha256md_pkg::ST_ROUND: begin
				cctl.round = 1'b1;
				sctl.step  = 1'b1;
			end
			sha256md_pkg::ST_FOLD: begin
				cctl.fold = 1'b1;
			end
			sha256md_pkg::ST_OUT: begin
				out_valid   = 1'b1;
				cctl.reinit = out_fire && (oidx_q == 3'd7);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256md_pkg::ST_IDLE;
			after_q <= sha256md_pkg::ST_IDLE;
			bib_q   <= '0;
			len_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			if (in_fire && in_data.has_byte) begin
				bib_q <= bib_q + 6'd1;
				len_q <= len_q + 61'd1;
			end
			if (state_q == sha256md_pkg::ST_PAD) begin
				bib_q <= '0;
			end
			if (state_q == sha256md_pkg::ST_LOAD) begin
				rnd_q <= '0;
			end else if (state_q == sha256md_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (out_fire) begin
				oidx_q <= oidx_q + 3'd1;
				// drop the length once the message is out
				if (oidx_q == 3'd7) begin
					len_q <= '0;
				end
			end
		end
	end

	sha256md_sched u_sched (
		.clk  (clk),
		.ctl  (sctl),
		.word (sched_word)
	);

	sha256md_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cctl),
		.w       (sched_word),
		.k       (sha256md_pkg::round_k(rnd_q)),
		.rd_idx  (oidx_q),
		.rd_word (chain_word)
	);

	assign out_data.digest_word = chain_word;
	assign out_data.last_word   = (oidx_q == 3'd7);

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("in_ready and out_valid high together");

	a_last_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out_data.last_word) |=> in_ready)
		else $error("block not idle after last digest word");

	a_fold_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256md_pkg::ST_FOLD) |-> ($past(state_q) == sha256md_pkg::ST_ROUND))
		else $error("fold without a preceding round");

	a_full_block_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.has_byte && (bib_q == 6'd63)) |=> (state_q == sha256md_pkg::ST_LOAD))
		else $error("full block not compressed");

endmodule

`default_nettype wire
